// File: rtl/hsv_skin_pixel_classifier_assert.svh
// Assertion macros for the HSV skin pixel classifier.
// Used by the top level; expects signals named clock and reset in scope.
`ifndef HSV_SKIN_PIXEL_CLASSIFIER_ASSERT_SVH
`define HSV_SKIN_PIXEL_CLASSIFIER_ASSERT_SVH
`ifndef SYNTHESIS
`define HSP_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("hsv skin classifier check failed");
`define HSP_NEVER(label, cond) `HSP_ASSERT(label, !(cond))
`else
`define HSP_ASSERT(label, prop)
`define HSP_NEVER(label, cond)
`endif
`endif

// File: rtl/hsp_pkg.sv
// Shared types and constants of the HSV skin pixel classifier.
// No dependencies; imported by every module of the block.
package hsp_pkg;

   localparam int CHAN_W     = 8;
   localparam int QUOT_W     = 12;
   localparam int HUE_W      = 15;
   localparam int RANGE_W    = 14;
   localparam int SAT_W      = 9;
   localparam int CSR_DATA_W = 15;
   localparam int CSR_IDX_W  = 2;

   // Divider layout: twelve quotient bits, three per stage.
   localparam int DIV_STEPS  = 3;
   localparam int DIV_STAGES = QUOT_W / DIV_STEPS;

   localparam logic [HUE_W-1:0]  HUE_FULL   = 15'd23040;
   localparam logic [HUE_W-1:0]  HUE_HALF   = 15'd11520;
   localparam logic [HUE_W-1:0]  HUE_GREEN  = 15'd7680;
   localparam logic [HUE_W-1:0]  HUE_BLUE   = 15'd15360;
   localparam logic [QUOT_W-1:0] QUOT_MAX   = 12'd3840;

   localparam logic [HUE_W-1:0]   HUE_CENTER_RESET = 15'd1600;
   localparam logic [RANGE_W-1:0] HUE_RANGE_RESET  = 14'd2560;
   localparam logic [SAT_W-1:0]   SAT_MIN_RESET    = 9'd38;
   localparam logic [CHAN_W-1:0]  VAL_MIN_RESET    = 8'd26;

   localparam logic [CSR_IDX_W-1:0] CSR_HUE_CENTER = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HUE_RANGE  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SAT_MIN    = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_VAL_MIN    = 2'd3;

   typedef enum logic [1:0] {
      SECTOR_RED,
      SECTOR_GREEN,
      SECTOR_BLUE
   } sector_type;

   typedef struct packed {
      sector_type sector;
      logic       neg;
      logic       zero_d;
      logic       sv_ok;
   } side_type;

   typedef struct packed {
      logic [CHAN_W-1:0] p;
      logic [QUOT_W-1:0] lq;
      logic [CHAN_W-1:0] d;
      side_type          side;
   } div_type;

endpackage

// File: rtl/hsp_front.sv
// Input stage: channel max/min, hue sector, divider operands, saturation and value tests.
// Depends on hsp_pkg.
module hsp_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  logic [hsp_pkg::CHAN_W-1:0]   red,
   input  logic [hsp_pkg::CHAN_W-1:0]   green,
   input  logic [hsp_pkg::CHAN_W-1:0]   blue,
   input  logic [hsp_pkg::SAT_W-1:0]    sat_min,
   input  logic [hsp_pkg::CHAN_W-1:0]   val_min,
   output logic                         out_valid,
   input  logic                         out_ready,
   output hsp_pkg::div_type             out_data
);
   import hsp_pkg::*;

   logic              valid_ff;
   div_type           data_ff, data_in;
   logic [CHAN_W-1:0] mx, mn, mag;
   logic signed [CHAN_W:0] a;
   logic [CHAN_W:0]   mag9;
   logic [QUOT_W-1:0] m15;
   logic [16:0]       sat_lhs, sat_rhs;
   logic              sat_ok, val_ok;
   logic              load;

   assign load     = !valid_ff || out_ready;
   assign in_ready = load;

   always_comb begin
      mx = red;
      if (green > mx) mx = green;
      if (blue > mx) mx = blue;
      mn = red;
      if (green < mn) mn = green;
      if (blue < mn) mn = blue;

      // Ties go to red first, then green.
      if (mx == red) begin
         data_in.side.sector = SECTOR_RED;
         a = $signed({1'b0, green}) - $signed({1'b0, blue});
      end else if (mx == green) begin
         data_in.side.sector = SECTOR_GREEN;
         a = $signed({1'b0, blue}) - $signed({1'b0, red});
      end else begin
         data_in.side.sector = SECTOR_BLUE;
         a = $signed({1'b0, red}) - $signed({1'b0, green});
      end

      mag9 = a[CHAN_W] ? (CHAN_W+1)'(-a) : (CHAN_W+1)'(a);
      mag  = mag9[CHAN_W-1:0];
      // 3840 * mag = (15 * mag) << 8. The top eight bits start the remainder.
      m15  = {mag, 4'b0000} - {4'b0000, mag};

      data_in.p  = m15[QUOT_W-1:4];
      data_in.lq = {m15[3:0], 8'b0000_0000};
      data_in.d  = mx - mn;
      data_in.side.neg    = a[CHAN_W];
      data_in.side.zero_d = (mx == mn);

      sat_lhs = {1'b0, data_in.d, 8'b0000_0000};
      sat_rhs = 17'(sat_min) * 17'(mx);
      // A black pixel has zero saturation.
      sat_ok  = (mx == '0) ? (sat_min == '0) : (sat_lhs >= sat_rhs);
      val_ok  = (mx >= val_min);
      data_in.side.sv_ok = sat_ok && val_ok;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// File: rtl/hsp_div_stage.sv
// One divider stage: three restoring steps of the hue quotient, with its own register.
// Depends on hsp_pkg.
module hsp_div_stage (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  hsp_pkg::div_type in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output hsp_pkg::div_type out_data
);
   import hsp_pkg::*;

   logic            valid_ff;
   div_type         data_ff, data_in;
   logic [CHAN_W:0] t;
   logic            qbit;
   logic            load;

   assign load     = !valid_ff || out_ready;
   assign in_ready = load;

   // The remainder stays below the divisor; lq shifts numerator bits out
   // and quotient bits in.
   always_comb begin
      data_in = in_data;
      t       = '0;
      qbit    = 1'b0;
      for (int j = 0; j < DIV_STEPS; j++) begin
         t    = {data_in.p, data_in.lq[QUOT_W-1]};
         qbit = (t >= {1'b0, data_in.d});
         if (qbit) begin
            t = t - {1'b0, data_in.d};
         end
         data_in.p  = t[CHAN_W-1:0];
         data_in.lq = {data_in.lq[QUOT_W-2:0], qbit};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// File: rtl/hsp_hue_cmp.sv
// Hue assembly, circular distance to the centre and the final skin decision (two stages).
// Depends on hsp_pkg.
module hsp_hue_cmp (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  hsp_pkg::div_type            in_data,
   input  logic [hsp_pkg::HUE_W-1:0]   hue_center,
   input  logic [hsp_pkg::RANGE_W-1:0] hue_range,
   output logic                        out_valid,
   input  logic                        out_ready,
   output logic                        out_skin
);
   import hsp_pkg::*;

   logic                    a_valid_ff, b_valid_ff;
   logic signed [HUE_W:0]   diff_ff, diff_in;
   logic                    ok_ff;
   logic                    skin_ff, skin_in;
   logic                    a_load, b_load;
   logic [HUE_W-1:0]        q15, base, h, c, adh, fold;

   assign b_load   = !b_valid_ff || out_ready;
   assign a_load   = !a_valid_ff || b_load;
   assign in_ready = a_load;

   always_comb begin
      q15 = HUE_W'(in_data.lq);
      unique case (in_data.side.sector)
         SECTOR_RED:   base = in_data.side.neg ? HUE_FULL : '0;
         SECTOR_GREEN: base = HUE_GREEN;
         SECTOR_BLUE:  base = HUE_BLUE;
         default:      base = '0;
      endcase
      if (in_data.side.zero_d) begin
         h = '0;
      end else if (in_data.side.neg) begin
         h = base - q15;
      end else begin
         h = base + q15;
      end
      c       = (hue_center >= HUE_FULL) ? hue_center - HUE_FULL : hue_center;
      diff_in = $signed({1'b0, h}) - $signed({1'b0, c});
   end

   always_comb begin
      adh     = diff_ff[HUE_W] ? HUE_W'(-diff_ff) : diff_ff[HUE_W-1:0];
      fold    = (adh > HUE_HALF) ? HUE_FULL - adh : adh;
      skin_in = ok_ff && (fold <= {1'b0, hue_range});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         if (a_load) a_valid_ff <= in_valid;
         if (b_load) b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (a_load && in_valid) begin
         diff_ff <= diff_in;
         ok_ff   <= in_data.side.sv_ok;
      end
      if (b_load && a_valid_ff) begin
         skin_ff <= skin_in;
      end
   end

   assign out_valid = b_valid_ff;
   assign out_skin  = skin_ff;

endmodule

// File: rtl/hsv_skin_pixel_classifier.sv
// Top level of the HSV skin pixel classifier: threshold registers and the pipeline.
// Depends on hsp_pkg, hsp_front, hsp_div_stage, hsp_hue_cmp and the assertion header.
//
//   channel   direction   handshake            payload
//   req       in          req_valid/req_stall  req_red, req_green, req_blue
//   rsp       out         rsp_valid/rsp_stall  rsp_skin
//   csr       in          csr_write            csr_index, csr_data
//
// One pixel is taken per cycle while req_stall is low, and its flag reaches rsp_skin
// through seven register stages: an input stage, four divider stages (the twelve-bit
// hue quotient, three restoring steps each) and two compare stages.
// Reset clears every stage's valid bit and loads the default thresholds.
// A stall at the result side holds the last stage; earlier stages keep moving into
// empty slots, so req_stall rises only when every stage holds a request.
module hsv_skin_pixel_classifier (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [hsp_pkg::CHAN_W-1:0]      req_red,
   input  logic [hsp_pkg::CHAN_W-1:0]      req_green,
   input  logic [hsp_pkg::CHAN_W-1:0]      req_blue,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_skin,
   input  logic                            csr_write,
   input  logic [hsp_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [hsp_pkg::CSR_DATA_W-1:0]  csr_data
);
   import hsp_pkg::*;

`include "hsv_skin_pixel_classifier_assert.svh"

   // Threshold registers. Software must write them only while the pipeline is empty;
   // the block itself does not enforce this. Every stage reads them directly.
   logic [HUE_W-1:0]   hue_center_ff, hue_center_in;
   logic [RANGE_W-1:0] hue_range_ff, hue_range_in;
   logic [SAT_W-1:0]   sat_min_ff, sat_min_in;
   logic [CHAN_W-1:0]  val_min_ff, val_min_in;

   always_comb begin
      hue_center_in = hue_center_ff;
      hue_range_in  = hue_range_ff;
      sat_min_in    = sat_min_ff;
      val_min_in    = val_min_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_HUE_CENTER: hue_center_in = csr_data;
            CSR_HUE_RANGE:  hue_range_in  = csr_data[RANGE_W-1:0];
            CSR_SAT_MIN:    sat_min_in    = csr_data[SAT_W-1:0];
            CSR_VAL_MIN:    val_min_in    = csr_data[CHAN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hue_center_ff <= HUE_CENTER_RESET;
         hue_range_ff  <= HUE_RANGE_RESET;
         sat_min_ff    <= SAT_MIN_RESET;
         val_min_ff    <= VAL_MIN_RESET;
      end else begin
         hue_center_ff <= hue_center_in;
         hue_range_ff  <= hue_range_in;
         sat_min_ff    <= sat_min_in;
         val_min_ff    <= val_min_in;
      end
   end

   // Slot 0 is the input stage; slot k is the output of divider stage k.
   logic [DIV_STAGES:0] div_valid;
   logic [DIV_STAGES:0] div_ready;
   div_type             div_data [DIV_STAGES+1];
   logic                front_ready;

   hsp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (front_ready),
      .red       (req_red),
      .green     (req_green),
      .blue      (req_blue),
      .sat_min   (sat_min_ff),
      .val_min   (val_min_ff),
      .out_valid (div_valid[0]),
      .out_ready (div_ready[0]),
      .out_data  (div_data[0])
   );

   assign req_stall = !front_ready;

   for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
      hsp_div_stage u_div (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (div_valid[k]),
         .in_ready  (div_ready[k]),
         .in_data   (div_data[k]),
         .out_valid (div_valid[k+1]),
         .out_ready (div_ready[k+1]),
         .out_data  (div_data[k+1])
      );
   end

   hsp_hue_cmp u_hue (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (div_valid[DIV_STAGES]),
      .in_ready   (div_ready[DIV_STAGES]),
      .in_data    (div_data[DIV_STAGES]),
      .hue_center (hue_center_ff),
      .hue_range  (hue_range_ff),
      .out_valid  (rsp_valid),
      .out_ready  (!rsp_stall),
      .out_skin   (rsp_skin)
   );

   // Divider conditions that the checks below watch.
   logic rem_start_bad, rem_end_bad, quot_bad;

   assign rem_start_bad = div_valid[0] && !div_data[0].side.zero_d
                          && (div_data[0].p >= div_data[0].d);
   assign rem_end_bad   = div_valid[DIV_STAGES] && !div_data[DIV_STAGES].side.zero_d
                          && (div_data[DIV_STAGES].p >= div_data[DIV_STAGES].d);
   assign quot_bad      = div_valid[DIV_STAGES] && !div_data[DIV_STAGES].side.zero_d
                          && (div_data[DIV_STAGES].lq > QUOT_MAX);

   // A taken request always lands in the input stage.
   `HSP_ASSERT(a_accept_lands, (req_valid && !req_stall) |=> div_valid[0])
   // Back pressure reaches the input only when the divider is full.
   `HSP_ASSERT(a_stall_full, req_stall |-> (&div_valid))
   // The partial remainder starts below the divisor.
   `HSP_NEVER(a_rem_start, rem_start_bad)
   // The remainder still stays below the divisor after the last step.
   `HSP_NEVER(a_rem_end, rem_end_bad)
   // A sector offset never exceeds one sixth of the circle.
   `HSP_NEVER(a_quot_max, quot_bad)

endmodule
